// File: hdl/fps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fps_pkg
// Types and fixed constants shared by the free page stack modules.
// ----------------------------------------------------------------------------
package fps_pkg;

  localparam int PageW  = 40;
  localparam int CountW = 5;
  localparam int CapW   = 13;
  localparam int ApbAw  = 3;
  localparam int ApbDw  = 32;

  localparam logic [CapW-1:0] CapReset = 13'd4096;

  // register index, taken from paddr[2]
  localparam logic RegCapacity = 1'b0;

  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OOM = 2'd1,
    ST_BAD = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_POP  = 1'b1
  } state_e;

  typedef struct packed {
    logic              mode;
    logic [CountW-1:0] batch_count;
    logic              linear;
    logic [PageW-1:0]  page_number;
    logic              last_in;
  } in_req_t;

  typedef struct packed {
    status_e          status;
    logic [PageW-1:0] page_out;
    logic             page_valid;
    logic             last_out;
  } out_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic take;
    logic pop_en;
  } fps_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;
    logic alloc_pop;
    logic pop_pending;
    logic rd_valid;
  } fps_sts_t;

endpackage
`default_nettype wire

// File: hdl/fps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fps_ctrl
// Sequencer: takes requests while idle, holds the input during a page pop.
// ----------------------------------------------------------------------------
module fps_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire fps_pkg::fps_sts_t sts_i,
  output fps_pkg::fps_cmd_t      cmd_o
);
  import fps_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !sts_i.out_busy && sts_i.alloc_pop) begin
          state_d = S_POP;
        end
      end
      S_POP: begin
        // done once the last read has been handed to the output register
        if (!sts_i.pop_pending && !sts_i.rd_valid) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o   = 1'b1;
    cmd_o.take   = 1'b0;
    cmd_o.pop_en = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = sts_i.out_busy;
        cmd_o.take = in_valid_i && !sts_i.out_busy;
      end
      S_POP: begin
        cmd_o.pop_en = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/fps_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fps_datapath
// Stack memory, stack pointer, free batch tracking, pop read pipeline and
// output register.
// ----------------------------------------------------------------------------
module fps_datapath #(
  parameter int STACK_DEPTH = 4096,
  parameter int MAX_BATCH   = 16,
  parameter int FRAME_BITS  = 40
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire fps_pkg::in_req_t             in_data_i,
  input  wire logic [fps_pkg::CapW-1:0]     capacity_i,
  input  wire fps_pkg::fps_cmd_t            cmd_i,
  output fps_pkg::fps_sts_t                 sts_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output fps_pkg::out_rsp_t                 out_data_o
);
  import fps_pkg::*;

  localparam int TopBits   = $clog2(STACK_DEPTH + 1);
  localparam int AddrBits  = $clog2(STACK_DEPTH);
  localparam int CmpBits   = ((TopBits > CapW) ? TopBits : CapW) + 1;
  localparam int StoreBits = (FRAME_BITS < PageW) ? FRAME_BITS : PageW;

  logic [StoreBits-1:0] mem [STACK_DEPTH];
  logic [StoreBits-1:0] rd_data_q;

  logic [TopBits-1:0]  top_q;
  logic                in_free_q;
  logic                rej_q;
  logic [AddrBits-1:0] rd_addr_q;
  logic [CountW-1:0]   remaining_q;
  logic                rd_valid_q;
  logic                rd_last_q;
  logic                out_valid_q;
  out_rsp_t            out_q;

  logic [CmpBits-1:0] cmp_top, cmp_cnt, cmp_cap, cmp_depth, eff_cap;
  logic               over_max, alloc_bad, alloc_oom, alloc_pop;
  logic               rej_in, push, rej_now;
  logic               has_rsp, mem_we, rd_en, load_out, out_busy;
  out_rsp_t           rsp;

  always_comb begin
    cmp_top   = CmpBits'(top_q);
    cmp_cnt   = CmpBits'(in_data_i.batch_count);
    cmp_cap   = CmpBits'(capacity_i);
    cmp_depth = CmpBits'(STACK_DEPTH);
    eff_cap   = (cmp_cap > cmp_depth) ? cmp_depth : cmp_cap;
    over_max  = cmp_cnt > CmpBits'(MAX_BATCH);

    alloc_bad = in_data_i.linear || over_max;
    alloc_oom = cmp_cnt > cmp_top;
    alloc_pop = (in_data_i.mode == ModeAlloc) && !alloc_bad && !alloc_oom &&
                (in_data_i.batch_count != '0);

    // first item of a free batch checks the whole batch
    if (!in_free_q) begin
      rej_in = (in_data_i.batch_count == '0) || over_max ||
               ((cmp_top + cmp_cnt) > eff_cap);
    end else begin
      rej_in = rej_q;
    end
    push    = !rej_in && (cmp_top < eff_cap);
    rej_now = rej_in || !push;

    rsp.page_out   = '0;
    rsp.page_valid = 1'b0;
    rsp.last_out   = 1'b1;
    if (in_data_i.mode == ModeAlloc) begin
      has_rsp = !alloc_pop;
      if (alloc_bad) begin
        rsp.status = ST_BAD;
      end else if (alloc_oom) begin
        rsp.status = ST_OOM;
      end else begin
        rsp.status = ST_OK;
      end
    end else begin
      has_rsp    = in_data_i.last_in;
      rsp.status = rej_now ? ST_BAD : ST_OK;
    end
  end

  assign out_busy = out_valid_q && out_stall_i;
  assign mem_we   = cmd_i.take && (in_data_i.mode == ModeFree) && push;
  assign load_out = rd_valid_q && !out_busy;
  assign rd_en    = cmd_i.pop_en && (remaining_q != '0) && (!rd_valid_q || load_out);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[top_q[AddrBits-1:0]] <= in_data_i.page_number[StoreBits-1:0];
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= '0;
      in_free_q   <= 1'b0;
      rej_q       <= 1'b0;
      remaining_q <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        if (in_data_i.mode == ModeAlloc) begin
          in_free_q <= 1'b0;
          rej_q     <= 1'b0;
          if (alloc_pop) begin
            top_q       <= TopBits'(cmp_top - cmp_cnt);
            remaining_q <= in_data_i.batch_count;
          end
        end else begin
          if (push) begin
            top_q <= top_q + TopBits'(1);
          end
          in_free_q <= !in_data_i.last_in;
          rej_q     <= !in_data_i.last_in && rej_now;
        end
      end else if (rd_en) begin
        remaining_q <= remaining_q - CountW'(1);
      end

      if (rd_en) begin
        rd_valid_q <= 1'b1;
      end else if (load_out) begin
        rd_valid_q <= 1'b0;
      end

      if ((cmd_i.take && has_rsp) || load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // pop addresses and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && alloc_pop) begin
      rd_addr_q <= AddrBits'(cmp_top - cmp_cnt);
    end else if (rd_en) begin
      rd_addr_q <= rd_addr_q + AddrBits'(1);
    end
    if (rd_en) begin
      rd_last_q <= (remaining_q == CountW'(1));
    end
    if (cmd_i.take && has_rsp) begin
      out_q <= rsp;
    end else if (load_out) begin
      out_q.status     <= ST_OK;
      out_q.page_out   <= PageW'(rd_data_q);
      out_q.page_valid <= 1'b1;
      out_q.last_out   <= rd_last_q;
    end
  end

  assign sts_o.out_busy    = out_busy;
  assign sts_o.alloc_pop   = alloc_pop;
  assign sts_o.pop_pending = remaining_q != '0;
  assign sts_o.rd_valid    = rd_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: hdl/free_page_stack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// free_page_stack
// Free page-frame stack serving batched allocate and free requests.
// ----------------------------------------------------------------------------
// A free page item, or an allocate answered by a single status, does not hold
// the input; the block is then ready for the next request as soon as the
// output register can take a result. An allocate of N pages pops the stack
// with one read of the single-port stack memory per page and holds the input
// until the last read reaches the output register, emitting one page per
// cycle while the output is not stalled. Pages come out from the lowest stack
// position upward, the last one marked. The stack starts empty and is filled
// only by free batches. The capacity register sits at APB address 0; a value
// above STACK_DEPTH acts as STACK_DEPTH.
module free_page_stack #(
  parameter int STACK_DEPTH = 4096,
  parameter int MAX_BATCH   = 16,
  parameter int FRAME_BITS  = 40
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire fps_pkg::in_req_t              in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output fps_pkg::out_rsp_t                  out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fps_pkg::ApbAw-1:0]     paddr,
  input  wire logic [fps_pkg::ApbDw-1:0]     pwdata,
  output logic [fps_pkg::ApbDw-1:0]          prdata,
  output logic                               pready
);
  import fps_pkg::*;

  logic [CapW-1:0] capacity_q;
  fps_cmd_t        cmd;
  fps_sts_t        sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegCapacity)) begin
      capacity_q <= pwdata[CapW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegCapacity) begin
      prdata = ApbDw'(capacity_q);
    end
  end

  fps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fps_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_BATCH   (MAX_BATCH),
    .FRAME_BITS  (FRAME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .capacity_i  (capacity_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // no new request while pages of an allocate are still being read
  a_no_take_during_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.pop_pending |-> in_stall_o)
    else $error("request taken during page pop");

  a_take_excl_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.take && cmd.pop_en))
    else $error("take and pop in the same cycle");

  a_status_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.page_valid) |-> out_data_o.last_out)
    else $error("status-only result not marked last");

  a_page_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.page_valid) |-> (out_data_o.status == ST_OK))
    else $error("page result with error status");

endmodule
`default_nettype wire
